/* hdl/nnis_pkg.sv */
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, constants and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	localparam int MAX_DIM_DEF = 256;

	localparam int COORD_W    = 8;
	localparam int PIX_W      = 32;
	localparam int SIZE_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIZE_W;

	// Column step: in_width * 2^16 / out_width, below 2^25
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = SIZE_W + FRAC_BITS;

	// Row reciprocal: ceil(2^26 / out_height), exact for cy * in_height < 2^17
	localparam int RCP_BITS = 26;
	localparam int RCP_W    = RCP_BITS + 1;

	// Shared serial divider width
	localparam int DIV_W = RCP_W;

	localparam int FIFO_D = 8;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_WIDTH   = 3'd0,
		REG_IN_HEIGHT  = 3'd1,
		REG_OUT_WIDTH  = 3'd2,
		REG_OUT_HEIGHT = 3'd3,
		REG_HAS_ALPHA  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic               err;
	} out_item_t;

	// Zero reads as one, values above the store size saturate
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input int max_dim);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > max_dim) begin
			r = SIZE_W'(max_dim);
		end
		return r;
	endfunction

endpackage

/* hdl/nnis_if.sv */
// ----------------------------------------------------------------------------
// nnis_if
// Valid/ready channels of the scaler: request, result and register write.
// ----------------------------------------------------------------------------
interface nnis_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [nnis_pkg::COORD_W-1:0] coord_x;
	logic [nnis_pkg::COORD_W-1:0] coord_y;
	logic [nnis_pkg::PIX_W-1:0]   pixel_in;

	modport source (output valid, operation, coord_x, coord_y, pixel_in, input ready);
	modport sink (input valid, operation, coord_x, coord_y, pixel_in, output ready);
endinterface

interface nnis_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [nnis_pkg::PIX_W-1:0]   pixel_out;
	logic [nnis_pkg::COORD_W-1:0] source_x;
	logic [nnis_pkg::COORD_W-1:0] source_y;
	logic                         range_error;

	modport source (output valid, pixel_out, source_x, source_y, range_error, input ready);
	modport sink (input valid, pixel_out, source_x, source_y, range_error, output ready);
endinterface

interface nnis_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nnis_pkg::CFG_IDX_W-1:0]  index;
	logic [nnis_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/nearest_neighbor_image_scaler_top.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Image store with nearest-neighbor fetch of scaled pixels.
//
//   channel | dir | payload                                        | accept
//   req     | in  | operation, coord_x, coord_y, pixel_in          | valid & ready
//   rsp     | out | pixel_out, source_x, source_y, range_error     | valid & ready
//   cfg     | in  | index, data                                    | valid & ready
//
// One item per clock while req.ready is high. A fetch result passes stages s1
// to s4 into an eight-entry output queue; the store access sits in the third stage.
// After reset and after each size write the serial divider recomputes the
// column step and row reciprocal; req and cfg are held off meanwhile.
// The store has no clearing pass. A stalled rsp only stops req once the
// queue cannot take every fetch in flight.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_top #(
	parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nnis_req_if.sink  req,
	nnis_rsp_if.source rsp,
	nnis_cfg_if.sink  cfg
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int AW     = $clog2(DEPTH);
	localparam int XP_W   = nnis_pkg::COORD_W + nnis_pkg::STEP_W;
	localparam int NP_W   = nnis_pkg::COORD_W + nnis_pkg::SIZE_W;
	localparam int YP_W   = NP_W + nnis_pkg::RCP_W;
	localparam int PTR_W  = $clog2(nnis_pkg::FIFO_D);
	localparam int CNT_W  = PTR_W + 1;
	localparam int SZ     = nnis_pkg::SIZE_W;
	localparam int CW     = nnis_pkg::COORD_W;
	localparam int PW     = nnis_pkg::PIX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_RCP
	} seq_t;

	// ---------------- configuration and scale factors ----------------
	logic [SZ-1:0] in_w_q, in_h_q, out_w_q, out_h_q;
	logic          has_alpha_q;
	seq_t          state_q;
	logic          kick_q;
	logic [nnis_pkg::STEP_W-1:0] step_q;
	logic [nnis_pkg::RCP_W-1:0]  rcp_q;
	nnis_pkg::div_req_t div_req_q;
	nnis_pkg::div_rsp_t div_rsp;
	logic          cfg_wr;
	logic          idle;

	assign idle      = (state_q == ST_IDLE) && !kick_q;
	assign cfg.ready = idle;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w_q      <= nnis_pkg::clamp_size(SZ'(256), MAX_DIM);
			in_h_q      <= nnis_pkg::clamp_size(SZ'(256), MAX_DIM);
			out_w_q     <= nnis_pkg::clamp_size(SZ'(256), MAX_DIM);
			out_h_q     <= nnis_pkg::clamp_size(SZ'(256), MAX_DIM);
			has_alpha_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg.index)
				nnis_pkg::REG_IN_WIDTH:   in_w_q  <= nnis_pkg::clamp_size(cfg.data, MAX_DIM);
				nnis_pkg::REG_IN_HEIGHT:  in_h_q  <= nnis_pkg::clamp_size(cfg.data, MAX_DIM);
				nnis_pkg::REG_OUT_WIDTH:  out_w_q <= nnis_pkg::clamp_size(cfg.data, MAX_DIM);
				nnis_pkg::REG_OUT_HEIGHT: out_h_q <= nnis_pkg::clamp_size(cfg.data, MAX_DIM);
				nnis_pkg::REG_HAS_ALPHA:  has_alpha_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kick_q    <= 1'b1;
			div_req_q <= '0;
			step_q    <= '0;
			rcp_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					div_req_q.start <= kick_q;
					if (kick_q) begin
						kick_q             <= 1'b0;
						div_req_q.dividend <= nnis_pkg::DIV_W'(in_w_q) << nnis_pkg::FRAC_BITS;
						div_req_q.divisor  <= out_w_q;
						state_q            <= ST_STEP;
					end else if (cfg_wr && (cfg.index inside {nnis_pkg::REG_IN_WIDTH,
						nnis_pkg::REG_IN_HEIGHT, nnis_pkg::REG_OUT_WIDTH,
						nnis_pkg::REG_OUT_HEIGHT})) begin
						kick_q <= 1'b1;
					end
				end
				ST_STEP: begin
					div_req_q.start <= div_rsp.done;
					if (div_rsp.done) begin
						step_q             <= div_rsp.quotient[nnis_pkg::STEP_W-1:0];
						// ceiling of 2^26 / out_height
						div_req_q.dividend <= (nnis_pkg::DIV_W'(1) << nnis_pkg::RCP_BITS)
							+ nnis_pkg::DIV_W'(out_h_q) - nnis_pkg::DIV_W'(1);
						div_req_q.divisor  <= out_h_q;
						state_q            <= ST_RCP;
					end
				end
				ST_RCP: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						rcp_q   <= div_rsp.quotient;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					div_req_q.start <= 1'b0;
					state_q         <= ST_IDLE;
				end
			endcase
		end
	end

	nnis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// ---------------- fetch pipeline ----------------
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               op_s1, op_s2, op_s3;
	logic [CW-1:0]      cx_s1, cx_s2, cx_s3;
	logic [CW-1:0]      cy_s1, cy_s2, cy_s3;
	logic [PW-1:0]      pix_s1, pix_s2, pix_s3;
	logic [XP_W-1:0]    xprod_s2, xfrac_s3;
	logic [NP_W-1:0]    nprod_s2;
	logic [YP_W-1:0]    yprod_s3;
	logic               err_s2, err_s3, err_s4;
	logic [SZ-1:0]      sx_s4, sy_s4;
	logic [PW-1:0]      rdata_s4;

	logic               req_acc;
	logic [SZ-1:0]      sx_raw, sy_raw, sx_cl, sy_cl;
	logic [AW-1:0]      waddr, raddr;
	logic               load_ok;
	logic [PW-1:0]      img_mem [DEPTH];

	// output queue
	nnis_pkg::out_item_t fifo_q [nnis_pkg::FIFO_D];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                push, pop;
	nnis_pkg::out_item_t push_item;
	logic [2:0]          inflight;
	logic [CNT_W:0]      occupancy;

	assign inflight = 3'(v_s1 && (op_s1 == nnis_pkg::OP_FETCH))
		+ 3'(v_s2 && (op_s2 == nnis_pkg::OP_FETCH))
		+ 3'(v_s3 && (op_s3 == nnis_pkg::OP_FETCH))
		+ 3'(v_s4);
	assign occupancy = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(inflight);
	assign req.ready = idle && (occupancy < (CNT_W+1)'(nnis_pkg::FIFO_D));
	assign req_acc   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (op_s3 == nnis_pkg::OP_FETCH);
		end
	end

	// s3 column and row, clamped into the store
	assign sx_raw  = xfrac_s3[nnis_pkg::FRAC_BITS +: SZ];
	assign sy_raw  = yprod_s3[nnis_pkg::RCP_BITS +: SZ];
	assign sx_cl   = (int'(sx_raw) >= MAX_DIM) ? SZ'(MAX_DIM - 1) : sx_raw;
	assign sy_cl   = (int'(sy_raw) >= MAX_DIM) ? SZ'(MAX_DIM - 1) : sy_raw;
	assign raddr   = AW'(int'(sy_cl) * MAX_DIM + int'(sx_cl));
	assign waddr   = AW'(int'(cy_s3) * MAX_DIM + int'(cx_s3));
	assign load_ok = (int'(cx_s3) < MAX_DIM) && (int'(cy_s3) < MAX_DIM);

	always_ff @(posedge clk) begin
		op_s1  <= req.operation;
		cx_s1  <= req.coord_x;
		cy_s1  <= req.coord_y;
		pix_s1 <= req.pixel_in;

		op_s2    <= op_s1;
		cx_s2    <= cx_s1;
		cy_s2    <= cy_s1;
		pix_s2   <= pix_s1;
		xprod_s2 <= XP_W'(cx_s1) * XP_W'(step_q);
		nprod_s2 <= NP_W'(cy_s1) * NP_W'(in_h_q);
		err_s2   <= ({1'b0, cx_s1} >= out_w_q) || ({1'b0, cy_s1} >= out_h_q);

		op_s3    <= op_s2;
		cx_s3    <= cx_s2;
		cy_s3    <= cy_s2;
		pix_s3   <= pix_s2;
		err_s3   <= err_s2;
		xfrac_s3 <= xprod_s2 + XP_W'(step_q >> 1);
		yprod_s3 <= YP_W'(nprod_s2) * YP_W'(rcp_q);

		sx_s4  <= sx_cl;
		sy_s4  <= sy_cl;
		err_s4 <= err_s3;
	end

	// loads and fetches reach the store in acceptance order at the same stage
	always_ff @(posedge clk) begin
		if (v_s3 && (op_s3 == nnis_pkg::OP_LOAD) && load_ok) begin
			img_mem[waddr] <= pix_s3;
		end
		if (v_s3 && (op_s3 == nnis_pkg::OP_FETCH)) begin
			rdata_s4 <= img_mem[raddr];
		end
	end

	always_comb begin
		push_item = '0;
		if (err_s4) begin
			push_item.err = 1'b1;
		end else begin
			push_item.pixel = has_alpha_q ? rdata_s4 : {8'h00, rdata_s4[PW-9:0]};
			push_item.sx    = sx_s4[CW-1:0];
			push_item.sy    = sy_s4[CW-1:0];
		end
	end

	assign push = v_s4;
	assign pop  = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

	assign rsp.valid       = cnt_q != '0;
	assign rsp.pixel_out   = fifo_q[rd_ptr_q].pixel;
	assign rsp.source_x    = fifo_q[rd_ptr_q].sx;
	assign rsp.source_y    = fifo_q[rd_ptr_q].sy;
	assign rsp.range_error = fifo_q[rd_ptr_q].err;

	// ---------------- assertions ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < CNT_W'(nnis_pkg::FIFO_D))
		else $error("output queue overflow");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> (state_q == ST_IDLE) && !div_rsp.busy && !div_req_q.start)
		else $error("item accepted while scale factors recompute");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && err_s4 |-> push_item.pixel == '0 && push_item.sx == '0
			&& push_item.sy == '0)
		else $error("range error result carries data");

	a_alpha_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !has_alpha_q |-> rsp.pixel_out[PW-1:PW-8] == 8'h00)
		else $error("alpha byte set in RGB mode");

	a_push_delay: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $past(v_s1, 3))
		else $error("result without accepted item");

endmodule

/* hdl/nnis_div.sv */
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle, for the scale factors.
// ----------------------------------------------------------------------------
module nnis_div (
	input  logic               clk,
	input  logic               arst_n,
	input  nnis_pkg::div_req_t req,
	output nnis_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(nnis_pkg::DIV_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [nnis_pkg::DIV_W-1:0]    quo_q;
	logic [nnis_pkg::SIZE_W-1:0]   rem_q;
	logic [nnis_pkg::SIZE_W-1:0]   dvs_q;

	logic [nnis_pkg::SIZE_W:0]     trial;
	logic                          ge;
	logic [nnis_pkg::SIZE_W:0]     diff;

	assign trial = {rem_q, quo_q[nnis_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(nnis_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= ge ? diff[nnis_pkg::SIZE_W-1:0] : trial[nnis_pkg::SIZE_W-1:0];
			quo_q <= {quo_q[nnis_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
